// ----- sv/vlrb_pkg.sv -----
`timescale 1ns / 1ps
package vlrb_pkg;

	localparam int DEFAULT_MAX_QUEUES = 4;
	localparam int DEFAULT_PAGE_BYTES = 4096;

	localparam int RING_ALIGN_MASK = 4095;
	localparam logic [7:0] DEV_CFG_BASE = 8'd20;

	// legacy BAR 0 layout
	localparam logic [7:0] PORT_DEV_FEAT   = 8'd0;
	localparam logic [7:0] PORT_DRV_FEAT   = 8'd4;
	localparam logic [7:0] PORT_QUEUE_PFN  = 8'd8;
	localparam logic [7:0] PORT_QUEUE_SIZE = 8'd12;
	localparam logic [7:0] PORT_QUEUE_SEL  = 8'd14;
	localparam logic [7:0] PORT_NOTIFY     = 8'd16;
	localparam logic [7:0] PORT_STATUS     = 8'd18;
	localparam logic [7:0] PORT_ISR        = 8'd19;

	localparam logic [2:0] BYTES_1 = 3'd1;
	localparam logic [2:0] BYTES_2 = 3'd2;
	localparam logic [2:0] BYTES_4 = 3'd4;

	localparam logic [1:0] CFG_OFFERED_FEATURES = 2'd0;
	localparam logic [1:0] CFG_QUEUE_COUNT      = 2'd1;
	localparam logic [1:0] CFG_GUEST_MEMORY     = 2'd2;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_USED  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		RC_OK    = 3'd0,
		RC_UNSUP = 3'd1,
		RC_SIZE  = 3'd2,
		RC_FEAT  = 3'd3,
		RC_RANGE = 3'd4,
		RC_DEV   = 3'd5
	} result_t;

endpackage

// ----- sv/virtio_legacy_register_block_unit.sv -----
`timescale 1ns / 1ps
// An accepted beat is registered in the input stage, then in the output register.
// Throughput: one beat per cycle while out_ready is high; with both stages full, in_ready follows out_ready.
// The PFN ring check is a single wide add of the page base and a narrow
// size-derived tail, then a compare against guest memory size.
// Reset (arst_n low, asynchronous): pipeline empty, device and queue state zero,
// configuration zero except queue_count one.
module virtio_legacy_register_block_unit
	import vlrb_pkg::*;
#(
	parameter int MAX_QUEUES = DEFAULT_MAX_QUEUES,
	parameter int PAGE_BYTES = DEFAULT_PAGE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [2:0]  bar_number,
	input  logic [7:0]  port_offset,
	input  logic [2:0]  access_bytes,
	input  logic [31:0] write_value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_code,
	output logic [31:0] read_value,
	output logic [2:0]  read_bytes,
	output logic        notify_strobe,
	output logic [1:0]  notify_queue,
	output logic        interrupt_pending,
	output logic [43:0] descriptor_base,
	output logic [43:0] avail_base,
	output logic [43:0] used_base,
	output logic [7:0]  dev_region_offset
);

	localparam int QSEL_W     = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int SUM_W      = 32 + PAGE_SHIFT + 2;
	localparam int CMP_W      = (SUM_W > 49) ? SUM_W : 49;
	localparam int RING_W     = 22;

	// configuration
	logic [31:0] offered_features_q;
	logic [2:0]  queue_count_q;
	logic [47:0] guest_memory_q;
	logic        cfg_wr;

	// architectural state
	logic [7:0]        device_status_q;
	logic [QSEL_W-1:0] queue_select_q;
	logic [7:0]        isr_q;
	logic [31:0]       queue_pfn_q  [MAX_QUEUES];
	logic [15:0]       queue_size_q [MAX_QUEUES];

	// input stage
	logic        valid_s1;
	mode_t       mode_s1;
	logic [2:0]  bar_s1;
	logic [7:0]  port_s1;
	logic [2:0]  bytes_s1;
	logic [31:0] wval_s1;
	logic        adv;

	// next state and results
	logic [7:0]        status_n;
	logic [QSEL_W-1:0] qsel_n;
	logic [7:0]        isr_n;
	logic              pfn_we;
	logic [31:0]       pfn_wd;
	logic              size_we;
	logic [15:0]       size_wd;
	result_t           code;
	logic [31:0]       rval;
	logic [2:0]        rbytes;
	logic              nstb;
	logic [1:0]        nq;
	logic [43:0]       desc_o;
	logic [43:0]       avail_o;
	logic [43:0]       used_o;
	logic [7:0]        doff;

	// queue decode
	logic [6:0]  live;
	logic        sel_ok;
	logic        v16_ok;
	logic [15:0] v16;
	logic [31:0] pfn_rd;
	logic [15:0] size_rd;

	// ring layout
	logic [RING_W-1:0] ring_hdr;
	logic [RING_W-1:0] ring_used;
	logic [RING_W-1:0] ring_tail;
	logic [SUM_W-1:0]  desc_w;
	logic [SUM_W-1:0]  avail_w;
	logic [SUM_W-1:0]  used_w;
	logic [CMP_W-1:0]  end_w;
	logic              ring_bad;

	logic        out_valid_q;
	result_t     code_q;
	logic [31:0] rval_q;
	logic [2:0]  rbytes_q;
	logic        nstb_q;
	logic [1:0]  nq_q;
	logic        irq_q;
	logic [43:0] desc_q;
	logic [43:0] avail_q;
	logic [43:0] used_q;
	logic [7:0]  doff_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offered_features_q <= '0;
			queue_count_q      <= 3'd1;
			guest_memory_q     <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				CFG_OFFERED_FEATURES: offered_features_q <= pwdata[31:0];
				CFG_QUEUE_COUNT:      queue_count_q      <= pwdata[2:0];
				CFG_GUEST_MEMORY:     guest_memory_q     <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			CFG_OFFERED_FEATURES: prdata = {32'd0, offered_features_q};
			CFG_QUEUE_COUNT:      prdata = {61'd0, queue_count_q};
			CFG_GUEST_MEMORY:     prdata = {16'd0, guest_memory_q};
			default:              prdata = '0;
		endcase
	end

	// handshake
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode_t'(mode);
			bar_s1   <= bar_number;
			port_s1  <= port_offset;
			bytes_s1 <= access_bytes;
			wval_s1  <= write_value;
		end
	end

	// queue decode
	assign live    = ({4'd0, queue_count_q} < 7'(MAX_QUEUES)) ? {4'd0, queue_count_q}
		: 7'(MAX_QUEUES);
	assign sel_ok  = 7'(queue_select_q) < live;
	assign v16     = wval_s1[15:0];
	assign v16_ok  = v16 < {9'd0, live};
	assign pfn_rd  = queue_pfn_q[queue_select_q];
	assign size_rd = queue_size_q[queue_select_q];

	// desc is page aligned, so the used ring offset depends on size alone
	assign ring_hdr  = RING_W'(size_rd) * RING_W'(18) + RING_W'(6);
	assign ring_used = (ring_hdr + RING_W'(RING_ALIGN_MASK)) & ~RING_W'(RING_ALIGN_MASK);
	assign ring_tail = ring_used + (RING_W'(size_rd) << 3) + RING_W'(6);
	assign desc_w    = SUM_W'(wval_s1) << PAGE_SHIFT;
	assign avail_w   = desc_w + (SUM_W'(size_rd) << 4);
	assign used_w    = desc_w + SUM_W'(ring_used);
	assign end_w     = CMP_W'(desc_w) + CMP_W'(ring_tail);
	assign ring_bad  = end_w > CMP_W'(guest_memory_q);

	always_comb begin
		status_n = device_status_q;
		qsel_n   = queue_select_q;
		isr_n    = isr_q;
		pfn_we   = 1'b0;
		pfn_wd   = wval_s1;
		size_we  = 1'b0;
		size_wd  = v16;
		code     = RC_OK;
		rval     = '0;
		rbytes   = '0;
		nstb     = 1'b0;
		nq       = '0;
		desc_o   = '0;
		avail_o  = '0;
		used_o   = '0;
		doff     = '0;
		case (mode_s1)
			MODE_USED: begin
				isr_n = isr_q | 8'd1;
			end
			MODE_READ: begin
				if (bar_s1 != 3'd0) begin
					code = RC_UNSUP;
				end else begin
					case (port_s1)
						PORT_DEV_FEAT: begin
							rval   = offered_features_q;
							rbytes = BYTES_4;
						end
						PORT_QUEUE_PFN: begin
							if (!sel_ok) begin
								code = RC_UNSUP;
							end else begin
								rval   = pfn_rd;
								rbytes = BYTES_4;
							end
						end
						PORT_QUEUE_SIZE: begin
							if (!sel_ok) begin
								code = RC_UNSUP;
							end else begin
								rval   = {16'd0, size_rd};
								rbytes = BYTES_2;
							end
						end
						PORT_STATUS: begin
							rval   = {24'd0, device_status_q};
							rbytes = BYTES_1;
						end
						PORT_ISR: begin
							rval   = {24'd0, isr_q};
							rbytes = BYTES_1;
							isr_n  = '0;
						end
						default: begin
							if (port_s1 >= DEV_CFG_BASE) begin
								code = RC_DEV;
								doff = port_s1 - DEV_CFG_BASE;
							end else begin
								code = RC_UNSUP;
							end
						end
					endcase
				end
			end
			MODE_WRITE: begin
				if (bar_s1 != 3'd0) begin
					code = RC_UNSUP;
				end else begin
					case (port_s1)
						PORT_DRV_FEAT: begin
							if (bytes_s1 != BYTES_4) begin
								code = RC_SIZE;
							end else if (wval_s1 != offered_features_q) begin
								code = RC_FEAT;
							end
						end
						PORT_STATUS: begin
							if (bytes_s1 != BYTES_1) begin
								code = RC_SIZE;
							end else begin
								status_n = wval_s1[7:0];
							end
						end
						PORT_QUEUE_PFN: begin
							if (bytes_s1 != BYTES_4) begin
								code = RC_SIZE;
							end else if (!sel_ok) begin
								code = RC_UNSUP;
							end else if (ring_bad) begin
								code    = RC_RANGE;
								pfn_we  = 1'b1;
								pfn_wd  = '0;
								size_we = 1'b1;
								size_wd = '0;
							end else begin
								pfn_we  = 1'b1;
								desc_o  = desc_w[43:0];
								avail_o = avail_w[43:0];
								used_o  = used_w[43:0];
							end
						end
						PORT_QUEUE_SIZE: begin
							if (bytes_s1 != BYTES_2) begin
								code = RC_SIZE;
							end else if (!sel_ok) begin
								code = RC_UNSUP;
							end else begin
								size_we = 1'b1;
							end
						end
						PORT_QUEUE_SEL: begin
							if (bytes_s1 != BYTES_2) begin
								code = RC_SIZE;
							end else if (!v16_ok) begin
								code = RC_UNSUP;
							end else begin
								qsel_n = v16[QSEL_W-1:0];
							end
						end
						PORT_NOTIFY: begin
							if (bytes_s1 != BYTES_2) begin
								code = RC_SIZE;
							end else if (!v16_ok) begin
								code = RC_UNSUP;
							end else begin
								nstb = 1'b1;
								nq   = v16[1:0];
							end
						end
						default: begin
							if (port_s1 >= DEV_CFG_BASE) begin
								code = RC_DEV;
								doff = port_s1 - DEV_CFG_BASE;
							end else begin
								code = RC_UNSUP;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_status_q <= '0;
			queue_select_q  <= '0;
			isr_q           <= '0;
		end else if (adv) begin
			device_status_q <= status_n;
			queue_select_q  <= qsel_n;
			isr_q           <= isr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_QUEUES; i++) begin
				queue_pfn_q[i]  <= '0;
				queue_size_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < MAX_QUEUES; i++) begin
				if (queue_select_q == QSEL_W'(i)) begin
					if (pfn_we) begin
						queue_pfn_q[i] <= pfn_wd;
					end
					if (size_we) begin
						queue_size_q[i] <= size_wd;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_q   <= code;
			rval_q   <= rval;
			rbytes_q <= rbytes;
			nstb_q   <= nstb;
			nq_q     <= nq;
			irq_q    <= isr_n != 8'd0;
			desc_q   <= desc_o;
			avail_q  <= avail_o;
			used_q   <= used_o;
			doff_q   <= doff;
		end
	end

	assign out_valid         = out_valid_q;
	assign result_code       = code_q;
	assign read_value        = rval_q;
	assign read_bytes        = rbytes_q;
	assign notify_strobe     = nstb_q;
	assign notify_queue      = nq_q;
	assign interrupt_pending = irq_q;
	assign descriptor_base   = desc_q;
	assign avail_base        = avail_q;
	assign used_base         = used_q;
	assign dev_region_offset = doff_q;

endmodule

// ----- sv/vlrb_checker.sv -----
`timescale 1ns / 1ps
module vlrb_checker
	import vlrb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_code,
	input logic [2:0]  read_bytes,
	input logic        notify_strobe,
	input logic [43:0] descriptor_base,
	input logic [7:0]  dev_region_offset
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_code))
		else $error("result beat changed while stalled");

	a_notify_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notify_strobe |-> result_code == RC_OK && read_bytes == 3'd0)
		else $error("notify strobe on a failed beat");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_bytes != 3'd0 |-> result_code == RC_OK && !notify_strobe)
		else $error("read data on a failed beat");

	a_ring_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && descriptor_base != 44'd0 |-> result_code == RC_OK)
		else $error("ring bases on a failed beat");

	a_devoff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_code != RC_DEV |-> dev_region_offset == 8'd0)
		else $error("device offset outside device-specific beat");

endmodule

bind virtio_legacy_register_block_unit vlrb_checker u_vlrb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.result_code      (result_code),
	.read_bytes       (read_bytes),
	.notify_strobe    (notify_strobe),
	.descriptor_base  (descriptor_base),
	.dev_region_offset(dev_region_offset)
);

// ----- tb/virtio_legacy_register_block_unit_tb.sv -----
`timescale 1ns / 1ps
module virtio_legacy_register_block_unit_tb;
	import vlrb_pkg::*;

	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 320;

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  bar;
		logic [7:0]  port;
		logic [2:0]  nbytes;
		logic [31:0] wval;
	} bus_access_t;

	typedef struct packed {
		logic [2:0]  code;
		logic [31:0] rval;
		logic [2:0]  rbytes;
		logic        nstb;
		logic [1:0]  nq;
		logic        irq;
		logic [43:0] desc;
		logic [43:0] avail;
		logic [43:0] used;
		logic [7:0]  doff;
	} bus_reply_t;

	class vlrb_scoreboard;
		logic [31:0] features;
		logic [2:0]  queue_count;
		logic [47:0] mem_bytes;
		logic [7:0]  dev_status;
		logic [1:0]  sel;
		logic [7:0]  isr;
		logic [31:0] page_frame [DEFAULT_MAX_QUEUES];
		logic [15:0] ring_size [DEFAULT_MAX_QUEUES];
		bus_reply_t  replies_due [$];
		int          mismatches;

		function new();
			features = '0;
			queue_count = 3'd1;
			mem_bytes = '0;
			dev_status = '0;
			sel = '0;
			isr = '0;
			foreach (page_frame[i]) begin
				page_frame[i] = '0;
				ring_size[i] = '0;
			end
			mismatches = 0;
		endfunction

		function int live();
			return (queue_count < DEFAULT_MAX_QUEUES) ? int'(queue_count) : DEFAULT_MAX_QUEUES;
		endfunction

		function string describe(bus_reply_t r);
			return $sformatf("code %0d rd %h/%0d ntf %b/%0d irq %b desc %h avail %h used %h doff %0d",
				r.code, r.rval, r.rbytes, r.nstb, r.nq, r.irq, r.desc, r.avail, r.used, r.doff);
		endfunction

		function void note_access(bus_access_t a);
			bus_reply_t  r;
			logic [15:0] v16;
			logic [63:0] sz, desc, avail, used_at, ring_end;
			logic        sel_ok;
			r = '0;
			r.code = RC_OK;
			v16 = a.wval[15:0];
			sel_ok = int'(sel) < live();
			if (a.mode == MODE_USED) begin
				isr = isr | 8'h01;
			end else if (a.mode == MODE_READ || a.mode == MODE_WRITE) begin
				if (a.bar != 3'd0) begin
					r.code = RC_UNSUP;
				end else if (a.mode == MODE_READ) begin
					case (a.port)
					PORT_DEV_FEAT: begin
						r.rval = features;
						r.rbytes = BYTES_4;
					end
					PORT_QUEUE_PFN, PORT_QUEUE_SIZE: begin
						if (!sel_ok) begin
							r.code = RC_UNSUP;
						end else if (a.port == PORT_QUEUE_PFN) begin
							r.rval = page_frame[sel];
							r.rbytes = BYTES_4;
						end else begin
							r.rval = 32'(ring_size[sel]);
							r.rbytes = BYTES_2;
						end
					end
					PORT_STATUS: begin
						r.rval = 32'(dev_status);
						r.rbytes = BYTES_1;
					end
					PORT_ISR: begin
						r.rval = 32'(isr);
						r.rbytes = BYTES_1;
						isr = '0;
					end
					default: begin
						if (a.port >= DEV_CFG_BASE) begin
							r.code = RC_DEV;
							r.doff = a.port - DEV_CFG_BASE;
						end else begin
							r.code = RC_UNSUP;
						end
					end
					endcase
				end else begin
					case (a.port)
					PORT_DRV_FEAT: begin
						if (a.nbytes != BYTES_4) r.code = RC_SIZE;
						else if (a.wval != features) r.code = RC_FEAT;
					end
					PORT_STATUS: begin
						if (a.nbytes != BYTES_1) r.code = RC_SIZE;
						else dev_status = a.wval[7:0];
					end
					PORT_QUEUE_PFN: begin
						if (a.nbytes != BYTES_4) begin
							r.code = RC_SIZE;
						end else if (!sel_ok) begin
							r.code = RC_UNSUP;
						end else begin
							// split ring: descriptors, avail (4-byte header), used page aligned
							sz = 64'(ring_size[sel]);
							desc = 64'(a.wval) * 64'(DEFAULT_PAGE_BYTES);
							avail = desc + 64'd16 * sz;
							used_at = (avail + 64'd4 + 64'd2 * sz + 64'd2 + 64'(RING_ALIGN_MASK))
								& ~64'(RING_ALIGN_MASK);
							ring_end = used_at + 64'd4 + 64'd8 * sz + 64'd2;
							page_frame[sel] = a.wval;
							if (ring_end > 64'(mem_bytes)) begin
								page_frame[sel] = '0;
								ring_size[sel] = '0;
								r.code = RC_RANGE;
							end else begin
								r.desc = desc[43:0];
								r.avail = avail[43:0];
								r.used = used_at[43:0];
							end
						end
					end
					PORT_QUEUE_SIZE: begin
						if (a.nbytes != BYTES_2) r.code = RC_SIZE;
						else if (!sel_ok) r.code = RC_UNSUP;
						else ring_size[sel] = v16;
					end
					PORT_QUEUE_SEL: begin
						if (a.nbytes != BYTES_2) r.code = RC_SIZE;
						else if (v16 >= live()) r.code = RC_UNSUP;
						else sel = v16[1:0];
					end
					PORT_NOTIFY: begin
						if (a.nbytes != BYTES_2) begin
							r.code = RC_SIZE;
						end else if (v16 >= live()) begin
							r.code = RC_UNSUP;
						end else begin
							r.nstb = 1'b1;
							r.nq = v16[1:0];
						end
					end
					default: begin
						if (a.port >= DEV_CFG_BASE) begin
							r.code = RC_DEV;
							r.doff = a.port - DEV_CFG_BASE;
						end else begin
							r.code = RC_UNSUP;
						end
					end
					endcase
				end
			end
			r.irq = (isr != 8'h00);
			replies_due.push_back(r);
		endfunction

		function void check_reply(bus_reply_t got);
			bus_reply_t want;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected reply: %s", describe(got));
				return;
			end
			want = replies_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply mismatch\n  expected %s\n  actual   %s",
						describe(want), describe(got));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [2:0]  bar_number;
	logic [7:0]  port_offset;
	logic [2:0]  access_bytes;
	logic [31:0] write_value;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  result_code;
	logic [31:0] read_value;
	logic [2:0]  read_bytes;
	logic        notify_strobe;
	logic [1:0]  notify_queue;
	logic        interrupt_pending;
	logic [43:0] descriptor_base;
	logic [43:0] avail_base;
	logic [43:0] used_base;
	logic [7:0]  dev_region_offset;

	vlrb_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holdoff_left = 0;
	int items_sent = 0;
	int cycle_count = 0;

	virtio_legacy_register_block_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.bar_number(bar_number),
		.port_offset(port_offset),
		.access_bytes(access_bytes),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_code(result_code),
		.read_value(read_value),
		.read_bytes(read_bytes),
		.notify_strobe(notify_strobe),
		.notify_queue(notify_queue),
		.interrupt_pending(interrupt_pending),
		.descriptor_base(descriptor_base),
		.avail_base(avail_base),
		.used_base(used_base),
		.dev_region_offset(dev_region_offset)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("virtio_legacy_register_block_unit_tb: errors");
		$finish;
	end

	// receiver: random stalls, plus long hold-offs requested by the stimulus
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : reply_monitor
		bus_reply_t got;
		if (arst_n && out_valid && out_ready) begin
			got.code = result_code;
			got.rval = read_value;
			got.rbytes = read_bytes;
			got.nstb = notify_strobe;
			got.nq = notify_queue;
			got.irq = interrupt_pending;
			got.desc = descriptor_base;
			got.avail = avail_base;
			got.used = used_base;
			got.doff = dev_region_offset;
			sb.check_reply(got);
		end
	end

	task automatic apb_write(input logic [4:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] feat, input logic [2:0] qc,
			input logic [47:0] mem);
		quiesce();
		apb_write({CFG_OFFERED_FEATURES, 3'b000}, 64'(feat));
		apb_write({CFG_QUEUE_COUNT, 3'b000}, 64'(qc));
		apb_write({CFG_GUEST_MEMORY, 3'b000}, 64'(mem));
		sb.features = feat;
		sb.queue_count = qc;
		sb.mem_bytes = mem;
	endtask

	task automatic send_access(input bus_access_t a);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= a.mode;
		bar_number <= a.bar;
		port_offset <= a.port;
		access_bytes <= a.nbytes;
		write_value <= a.wval;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_access(a);
		items_sent++;
	endtask

	function automatic bus_access_t make_access(input logic [1:0] m, input logic [2:0] bar,
			input logic [7:0] port, input logic [2:0] nb, input logic [31:0] v);
		bus_access_t a;
		a.mode = m;
		a.bar = bar;
		a.port = port;
		a.nbytes = nb;
		a.wval = v;
		return a;
	endfunction

	function automatic logic [15:0] queue_index();
		return ($urandom_range(9) < 8) ? 16'($urandom_range(3)) : 16'($urandom);
	endfunction

	function automatic logic [15:0] ring_entries();
		case ($urandom_range(4))
		0: return 16'($urandom_range(16));
		1: return 16'(1 << $urandom_range(15));
		2: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	// mostly frames that land inside guest memory, some near its top, some anywhere
	function automatic logic [31:0] frame_number();
		logic [63:0] pages;
		logic [31:0] lim;
		pages = 64'(sb.mem_bytes) >> 12;
		lim = (pages > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pages[31:0];
		if (lim == 0 || $urandom_range(9) < 2) return $urandom;
		if ($urandom_range(9) == 0) return lim - 32'($urandom_range(3));
		return $urandom_range(lim);
	endfunction

	function automatic bus_access_t register_access();
		bus_access_t a;
		a = make_access(MODE_WRITE, 3'd0, PORT_DEV_FEAT, BYTES_2, $urandom);
		case ($urandom_range(12))
		0: begin a.mode = MODE_READ; a.port = PORT_DEV_FEAT; end
		1: begin
			a.port = PORT_DRV_FEAT;
			a.nbytes = BYTES_4;
			if ($urandom_range(9) < 6) a.wval = sb.features;
		end
		2: begin a.mode = MODE_READ; a.port = PORT_QUEUE_PFN; end
		3: begin a.port = PORT_QUEUE_PFN; a.nbytes = BYTES_4; a.wval = frame_number(); end
		4: begin a.mode = MODE_READ; a.port = PORT_QUEUE_SIZE; end
		5: begin a.port = PORT_QUEUE_SIZE; a.wval[15:0] = ring_entries(); end
		6: begin a.port = PORT_QUEUE_SEL; a.wval[15:0] = queue_index(); end
		7: begin a.port = PORT_NOTIFY; a.wval[15:0] = queue_index(); end
		8: begin a.mode = MODE_READ; a.port = PORT_STATUS; end
		9: begin a.port = PORT_STATUS; a.nbytes = BYTES_1; end
		10: begin a.mode = MODE_READ; a.port = PORT_ISR; end
		11: begin a.mode = MODE_READ; a.port = 8'($urandom_range(DEV_CFG_BASE, 255)); end
		default: begin
			a.port = 8'($urandom_range(DEV_CFG_BASE, 255));
			a.nbytes = 3'($urandom_range(1, 4));
		end
		endcase
		if (a.mode == MODE_READ) a.nbytes = 3'($urandom_range(1, 4));
		if ($urandom_range(99) < 8) a.nbytes = 3'($urandom_range(7));
		if ($urandom_range(99) < 4) a.bar = 3'($urandom_range(1, 7));
		return a;
	endfunction

	function automatic bus_access_t noise_access();
		bus_access_t a;
		a = make_access(2'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom),
			3'($urandom_range(7)), $urandom);
		if ($urandom_range(1)) a.bar = 3'd0;
		return a;
	endfunction

	task automatic queue_setup();
		logic [15:0] q;
		q = 16'($urandom_range(sb.live() - 1));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_SEL, BYTES_2, {16'($urandom), q}));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_SIZE, BYTES_2,
			{16'($urandom), ring_entries()}));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_PFN, BYTES_4, frame_number()));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_NOTIFY, BYTES_2, {16'($urandom), q}));
		send_access(make_access(MODE_READ, 3'd0, PORT_QUEUE_PFN, BYTES_4, $urandom));
		if ($urandom_range(1))
			send_access(make_access(MODE_READ, 3'd0, PORT_QUEUE_SIZE, BYTES_2, $urandom));
	endtask

	initial begin
		int phase_start;
		bit held, paused;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		mode = MODE_READ;
		bar_number = '0;
		port_offset = '0;
		access_bytes = BYTES_4;
		write_value = '0;
		held = 1'b0;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, ring check against empty guest memory
		send_access(make_access(MODE_READ, 3'd0, PORT_DEV_FEAT, BYTES_4, 32'h0));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_PFN, BYTES_4, 32'h0));
		send_access(make_access(MODE_READ, 3'd0, PORT_ISR, BYTES_1, 32'h0));

		configure(32'hFFFF_FFFF, 3'd4, 48'hFFFF_FFFF_FFFF);
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_SEL, BYTES_2, 32'hFFFF_0003));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_SIZE, BYTES_2, 32'hABCD_FFFF));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_PFN, BYTES_4, 32'hFFFF_FFFF));
		send_access(make_access(MODE_READ, 3'd0, PORT_QUEUE_PFN, BYTES_1, 32'h0));
		send_access(make_access(MODE_READ, 3'd0, PORT_QUEUE_SIZE, BYTES_4, 32'h0));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_NOTIFY, BYTES_2, 32'h5A5A_0003));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_NOTIFY, BYTES_2, 32'h0000_0004));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_SEL, BYTES_2, 32'h0000_FFFF));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_SIZE, BYTES_4, 32'h0000_0010));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_DRV_FEAT, BYTES_4, 32'hFFFF_FFFF));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_DRV_FEAT, BYTES_4, 32'hFFFF_FFFE));
		send_access(make_access(MODE_USED, 3'd7, 8'hFF, 3'd7, 32'hFFFF_FFFF));
		send_access(make_access(MODE_READ, 3'd0, PORT_ISR, BYTES_1, 32'h0));
		send_access(make_access(MODE_READ, 3'd0, PORT_ISR, BYTES_1, 32'h0));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_STATUS, BYTES_1, 32'h1234_56FF));
		send_access(make_access(MODE_READ, 3'd0, PORT_STATUS, BYTES_1, 32'h0));
		send_access(make_access(MODE_READ, 3'd5, PORT_DEV_FEAT, BYTES_4, 32'h0));
		send_access(make_access(MODE_WRITE, 3'd4, PORT_STATUS, BYTES_1, 32'h0000_0011));
		send_access(make_access(MODE_RESERVED, 3'd0, PORT_ISR, BYTES_1, 32'h0));
		send_access(make_access(MODE_READ, 3'd0, 8'hFF, BYTES_4, 32'h0));
		send_access(make_access(MODE_WRITE, 3'd0, DEV_CFG_BASE, BYTES_2, 32'h0000_BEEF));
		send_access(make_access(MODE_READ, 3'd0, 8'd1, BYTES_1, 32'h0));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_ISR, BYTES_1, 32'h0000_0001));

		// queue 3 stays selected but no longer exists
		configure(32'h0, 3'd1, 48'hFFFF_FFFF_FFFF);
		send_access(make_access(MODE_READ, 3'd0, PORT_QUEUE_PFN, BYTES_4, 32'h0));
		send_access(make_access(MODE_WRITE, 3'd0, PORT_QUEUE_SIZE, BYTES_2, 32'h0000_0008));

		for (int p = 0; p < 6; p++) begin
			case (p)
			0: configure($urandom, 3'd4, 48'hFFFF_FFFF_FFFF);
			1: configure(32'h0, 3'd1, 48'h0);
			2: configure(32'hFFFF_FFFF, 3'd2, 48'h100_0000 + 48'($urandom_range(32'hFF_FFFF)));
			3: configure($urandom, 3'd3, {16'($urandom), 32'($urandom)});
			4: configure($urandom, 3'd4, 48'(64'h1 << $urandom_range(20, 40)));
			default: configure($urandom, 3'd2, 48'hFFFF_FFFF_FFFF);
			endcase
			if (p < 2) begin
				send_idle_pct = 15;
				recv_idle_pct = 70;
			end else if (p < 4) begin
				send_idle_pct = 70;
				recv_idle_pct = 15;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if (p == 0 && !held && items_sent - phase_start >= 100) begin
					held = 1'b1;
					holdoff_left = 400;
				end
				if (p == 2 && !paused && items_sent - phase_start >= 150) begin
					paused = 1'b1;
					quiesce();
				end
				case ($urandom_range(19))
				0, 1, 2, 3: queue_setup();
				4, 5: begin
					send_access(make_access(MODE_USED, 3'($urandom_range(7)), 8'($urandom),
						3'($urandom_range(7)), $urandom));
					send_access(make_access(MODE_READ, 3'd0, PORT_ISR, BYTES_1, $urandom));
				end
				16, 17, 18: send_access(noise_access());
				default: send_access(register_access());
				endcase
			end
		end

		quiesce();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("virtio_legacy_register_block_unit_tb: clean");
		end else begin
			$display("virtio_legacy_register_block_unit_tb: errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/vlrb_pkg.sv
sv/virtio_legacy_register_block_unit.sv
sv/vlrb_checker.sv
tb/virtio_legacy_register_block_unit_tb.sv
